[design/drp_pkg.sv]
// Shared types, constants and the saturation helper function of the disparity reprojection block.
package drp_pkg;

   localparam int COORD_BITS = 10;
   localparam int FRAC_BITS  = 16;
   localparam int NUM_COEFS  = 28;
   localparam int MIN_DISP   = 2;
   localparam int ROT_BASE   = 16;
   localparam int TRN_BASE   = 25;

   localparam int PROD_BITS    = 32 + COORD_BITS + 1;
   localparam int POS_BITS     = 32 + COORD_BITS + 3;
   localparam int DIV_STAGES   = 32;
   localparam int ROT_SUM_BITS = 66;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_PIXEL = 1'b1;

   localparam logic signed [31:0] WORD_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] WORD_MIN = 32'sh80000000;

   typedef struct packed {
      logic               mode;
      logic [4:0]         coef_index;
      logic signed [31:0] coef_value;
      logic [9:0]         pixel_col;
      logic [9:0]         pixel_row;
      logic [7:0]         disparity;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
   } req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic [23:0]        color_rgb;
      logic               degenerate;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] col;
      logic [COORD_BITS-1:0] row;
      logic [7:0]            disp;
      logic [23:0]           rgb;
   } pix_type;

   typedef logic [NUM_COEFS-1:0][31:0] coef_array_type;

   typedef struct packed {
      logic busy;
      logic take;
   } back_status_type;

   function automatic logic signed [31:0] sat_word(input logic signed [ROT_SUM_BITS-1:0] v);
      logic signed [31:0] r;
      if (v > ROT_SUM_BITS'(WORD_MAX)) begin
         r = WORD_MAX;
      end else if (v < ROT_SUM_BITS'(WORD_MIN)) begin
         r = WORD_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[design/drp_front.sv]
// Front end: coefficient store, item classification and the pixel queue.
module drp_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  drp_pkg::req_type           req_data,
   output logic                       pix_valid,
   output drp_pkg::pix_type           pix_data,
   input  drp_pkg::back_status_type   status,
   output drp_pkg::coef_array_type    coefs
);

   drp_pkg::coef_array_type coef_ff;
   drp_pkg::pix_type        q_ff [drp_pkg::QUEUE_DEPTH];
   logic [drp_pkg::QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [drp_pkg::QPTR_BITS:0]   count_ff;

   logic is_load, idle, accept, push_q, pop_q;
   drp_pkg::pix_type new_pix;

   assign is_load  = (req_data.mode == drp_pkg::MODE_LOAD);
   assign idle     = (count_ff == '0) && !status.busy;
   // A load waits until every earlier pixel has left the pipeline.
   assign req_full = (count_ff == (drp_pkg::QPTR_BITS+1)'(drp_pkg::QUEUE_DEPTH)) ||
                     (is_load && !idle);
   assign accept   = req_push && !req_full;
   assign push_q   = accept && !is_load && (req_data.disparity >= 8'(drp_pkg::MIN_DISP));
   assign pop_q    = status.take;

   assign pix_valid = (count_ff != '0);
   assign pix_data  = q_ff[rd_ptr_ff];
   assign coefs     = coef_ff;

   always_comb begin
      new_pix.col  = req_data.pixel_col[drp_pkg::COORD_BITS-1:0];
      new_pix.row  = req_data.pixel_row[drp_pkg::COORD_BITS-1:0];
      new_pix.disp = req_data.disparity;
      new_pix.rgb  = {req_data.red, req_data.green, req_data.blue};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff   <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (accept && is_load) begin
            for (int k = 0; k < drp_pkg::NUM_COEFS; k++) begin
               if (req_data.coef_index == 5'(k)) begin
                  coef_ff[k] <= req_data.coef_value;
               end
            end
         end
         if (push_q) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop_q) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push_q && !pop_q) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop_q && !push_q) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_q) begin
         q_ff[wr_ptr_ff] <= new_pix;
      end
   end

endmodule

[design/drp_divider.sv]
// Pipelined restoring divider lane, one quotient bit per stage.
module drp_divider (
   input  logic                          clock,
   input  logic                          en,
   input  logic [drp_pkg::POS_BITS-1:0]  src_rem,
   input  logic [drp_pkg::POS_BITS-1:0]  src_dvs,
   input  logic [31:0]                   src_low,
   output logic [31:0]                   quot
);

   localparam int PB = drp_pkg::POS_BITS;
   localparam int NS = drp_pkg::DIV_STAGES;

   logic [PB-1:0] rem_ff [NS];
   logic [PB-1:0] dvs_ff [NS];
   logic [31:0]   low_ff [NS];
   logic [31:0]   quot_ff [NS];
   logic [PB-1:0] rem_in [NS];
   logic [PB-1:0] dvs_in [NS];
   logic [31:0]   low_in [NS];
   logic [31:0]   quot_in [NS];

   always_comb begin
      logic [PB-1:0] p_rem, p_dvs;
      logic [31:0]   p_low, p_quot;
      logic [PB:0]   trial;
      for (int s = 0; s < NS; s++) begin
         if (s == 0) begin
            p_rem  = src_rem;
            p_dvs  = src_dvs;
            p_low  = src_low;
            p_quot = '0;
         end else begin
            p_rem  = rem_ff[s-1];
            p_dvs  = dvs_ff[s-1];
            p_low  = low_ff[s-1];
            p_quot = quot_ff[s-1];
         end
         trial = {p_rem, p_low[31]};
         if (trial >= {1'b0, p_dvs}) begin
            rem_in[s]  = PB'(trial - {1'b0, p_dvs});
            quot_in[s] = {p_quot[30:0], 1'b1};
         end else begin
            rem_in[s]  = PB'(trial);
            quot_in[s] = {p_quot[30:0], 1'b0};
         end
         dvs_in[s] = p_dvs;
         low_in[s] = {p_low[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         dvs_ff  <= dvs_in;
         low_ff  <= low_in;
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff[NS-1];

endmodule

[design/drp_back.sv]
// Back end: matrix product, division by w, rotation and translation, result queue.
module drp_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pix_valid,
   input  drp_pkg::pix_type           pix_data,
   output drp_pkg::back_status_type   status,
   input  drp_pkg::coef_array_type    coefs,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output drp_pkg::rsp_type           rsp_data
);

   localparam int PB = drp_pkg::POS_BITS;
   localparam int PR = drp_pkg::PROD_BITS;
   localparam int FB = drp_pkg::FRAC_BITS;
   localparam int CB = drp_pkg::COORD_BITS;
   localparam int SB = drp_pkg::ROT_SUM_BITS;
   localparam int NS = drp_pkg::DIV_STAGES;

   typedef struct packed {
      logic        valid;
      logic [23:0] rgb;
      logic        degen;
      logic [2:0]  neg;
      logic [2:0]  ovf;
      logic [2:0]  gt;
      logic [2:0]  lt;
   } side_type;

   logic en;

   // Stage A: the sixteen matrix products.
   logic                 a_valid_ff;
   logic [23:0]          a_rgb_ff;
   logic signed [PR-1:0] a_prod_ff [16];
   logic signed [PR-1:0] a_prod_in [16];

   // Stage B: homogeneous position.
   logic                 b_valid_ff;
   logic [23:0]          b_rgb_ff;
   logic signed [PB-1:0] b_pos_ff [4];
   logic signed [PB-1:0] b_pos_in [4];

   // Stage C: magnitudes and divider set-up.
   side_type      c_side_ff, c_side_in;
   logic [PB-1:0] c_rem_ff [3];
   logic [PB-1:0] c_rem_in [3];
   logic [31:0]   c_low_ff [3];
   logic [31:0]   c_low_in [3];
   logic [PB-1:0] c_dvs_ff, c_dvs_in;

   side_type    side_ff [NS];
   logic [31:0] quot [3];

   // Stage D: camera-frame coordinates.
   side_type           d_side_ff;
   logic signed [31:0] d_cam_ff [3];
   logic signed [31:0] d_cam_in [3];

   // Stage E: rotation products.
   side_type           e_side_ff;
   logic signed [63:0] e_rot_ff [9];
   logic signed [63:0] e_rot_in [9];

   // Stage F: finished result.
   logic             f_valid_ff;
   drp_pkg::rsp_type f_res_ff, f_res_in;

   drp_pkg::rsp_type oq_ff [drp_pkg::QUEUE_DEPTH];
   logic [drp_pkg::QPTR_BITS-1:0] oq_wr_ff, oq_rd_ff;
   logic [drp_pkg::QPTR_BITS:0]   oq_count_ff;
   logic oq_full, oq_push, oq_pop, any_side;

   assign oq_full = (oq_count_ff == (drp_pkg::QPTR_BITS+1)'(drp_pkg::QUEUE_DEPTH));
   assign en      = !(f_valid_ff && oq_full);
   assign oq_push = f_valid_ff && en;
   assign oq_pop  = rsp_pop && !rsp_empty;

   always_comb begin
      any_side = 1'b0;
      for (int s = 0; s < NS; s++) begin
         any_side = any_side | side_ff[s].valid;
      end
   end

   assign status.take = en && pix_valid;
   assign status.busy = a_valid_ff || b_valid_ff || c_side_ff.valid || any_side ||
                        d_side_ff.valid || e_side_ff.valid || f_valid_ff;

   always_comb begin
      logic signed [CB:0] opnd [3];
      opnd[0] = $signed({1'b0, pix_data.col});
      opnd[1] = $signed({1'b0, pix_data.row});
      opnd[2] = $signed({{(CB-7){1'b0}}, pix_data.disp});
      for (int r = 0; r < 4; r++) begin
         for (int j = 0; j < 3; j++) begin
            a_prod_in[r*4+j] = $signed(coefs[r*4+j]) * opnd[j];
         end
         a_prod_in[r*4+3] = PR'($signed(coefs[r*4+3]));
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         b_pos_in[r] = PB'(a_prod_ff[r*4]) + PB'(a_prod_ff[r*4+1]) +
                       PB'(a_prod_ff[r*4+2]) + PB'(a_prod_ff[r*4+3]);
      end
   end

   always_comb begin
      logic [PB-1:0]      mag_w, mag_n;
      logic [PB+FB-1:0]   num_sh;
      logic [PB+31:0]     wide_n, wide_w;
      logic               w_neg;
      w_neg    = b_pos_ff[3][PB-1];
      mag_w    = w_neg ? PB'(-b_pos_ff[3]) : PB'(b_pos_ff[3]);
      c_dvs_in = mag_w;
      c_side_in.valid = b_valid_ff;
      c_side_in.rgb   = b_rgb_ff;
      c_side_in.degen = (b_pos_ff[3] == '0);
      wide_w = {mag_w, 32'b0};
      for (int k = 0; k < 3; k++) begin
         mag_n  = b_pos_ff[k][PB-1] ? PB'(-b_pos_ff[k]) : PB'(b_pos_ff[k]);
         num_sh = {mag_n, {FB{1'b0}}};
         wide_n = (PB+32)'(num_sh);
         c_side_in.neg[k] = b_pos_ff[k][PB-1] ^ w_neg;
         c_side_in.ovf[k] = (wide_n >= wide_w);
         c_side_in.gt[k]  = !b_pos_ff[k][PB-1] && (b_pos_ff[k] != '0);
         c_side_in.lt[k]  = b_pos_ff[k][PB-1];
         c_rem_in[k] = PB'(num_sh[PB+FB-1:32]);
         c_low_in[k] = num_sh[31:0];
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_div
      drp_divider u_div (
         .clock   (clock),
         .en      (en),
         .src_rem (c_rem_ff[k]),
         .src_dvs (c_dvs_ff),
         .src_low (c_low_ff[k]),
         .quot    (quot[k])
      );
   end

   always_comb begin
      side_type ds;
      ds = side_ff[NS-1];
      for (int k = 0; k < 3; k++) begin
         if (ds.ovf[k]) begin
            d_cam_in[k] = ds.neg[k] ? drp_pkg::WORD_MIN : drp_pkg::WORD_MAX;
         end else if (!ds.neg[k]) begin
            d_cam_in[k] = quot[k][31] ? drp_pkg::WORD_MAX : $signed(quot[k]);
         end else if (quot[k] > 32'h80000000) begin
            d_cam_in[k] = drp_pkg::WORD_MIN;
         end else begin
            d_cam_in[k] = $signed(-quot[k]);
         end
      end
   end

   always_comb begin
      logic signed [63:0] prod;
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < 3; j++) begin
            prod = $signed(coefs[drp_pkg::ROT_BASE + k*3 + j]) * d_cam_ff[j];
            e_rot_in[k*3+j] = prod >>> FB;
         end
      end
   end

   always_comb begin
      logic signed [SB-1:0] acc;
      logic signed [31:0]   res [3];
      for (int k = 0; k < 3; k++) begin
         acc = SB'($signed(coefs[drp_pkg::TRN_BASE + k])) + SB'(e_rot_ff[k*3]) +
               SB'(e_rot_ff[k*3+1]) + SB'(e_rot_ff[k*3+2]);
         if (e_side_ff.degen) begin
            res[k] = e_side_ff.gt[k] ? drp_pkg::WORD_MAX :
                     (e_side_ff.lt[k] ? drp_pkg::WORD_MIN : 32'sd0);
         end else begin
            res[k] = drp_pkg::sat_word(acc);
         end
      end
      f_res_in.point_x    = res[0];
      f_res_in.point_y    = res[1];
      f_res_in.point_z    = res[2];
      f_res_in.color_rgb  = e_side_ff.rgb;
      f_res_in.degenerate = e_side_ff.degen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_side_ff  <= '0;
         for (int s = 0; s < NS; s++) begin
            side_ff[s] <= '0;
         end
         d_side_ff  <= '0;
         e_side_ff  <= '0;
         f_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= pix_valid;
         b_valid_ff <= a_valid_ff;
         c_side_ff  <= c_side_in;
         side_ff[0] <= c_side_ff;
         for (int s = 1; s < NS; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         d_side_ff  <= side_ff[NS-1];
         e_side_ff  <= d_side_ff;
         f_valid_ff <= e_side_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_rgb_ff  <= pix_data.rgb;
         a_prod_ff <= a_prod_in;
         b_rgb_ff  <= a_rgb_ff;
         b_pos_ff  <= b_pos_in;
         c_rem_ff  <= c_rem_in;
         c_low_ff  <= c_low_in;
         c_dvs_ff  <= c_dvs_in;
         d_cam_ff  <= d_cam_in;
         e_rot_ff  <= e_rot_in;
         f_res_ff  <= f_res_in;
      end
   end

   // Result queue: finished points wait here until they are transferred out.
   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff    <= '0;
         oq_rd_ff    <= '0;
         oq_count_ff <= '0;
      end else begin
         if (oq_push) begin
            oq_wr_ff <= oq_wr_ff + 1'b1;
         end
         if (oq_pop) begin
            oq_rd_ff <= oq_rd_ff + 1'b1;
         end
         if (oq_push && !oq_pop) begin
            oq_count_ff <= oq_count_ff + 1'b1;
         end else if (oq_pop && !oq_push) begin
            oq_count_ff <= oq_count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) begin
         oq_ff[oq_wr_ff] <= f_res_ff;
      end
   end

   assign rsp_empty = (oq_count_ff == '0);
   assign rsp_data  = oq_ff[oq_rd_ff];

endmodule

[design/disparity_to_point_reprojection.sv]
// Top level of the disparity-to-3D-point reprojection block.
// Items enter on the req_ queue port: a transfer happens when req_push is high
// and req_full is low. A load item writes one of the 28 Q16.16 coefficients
// (reprojection matrix, rotation, translation); a pixel item carries column,
// row, disparity and colour. Pixels with disparity below two are dropped.
// Every other pixel yields one point on the rsp_ queue port, transferred when
// rsp_pop is high and rsp_empty is low, oldest first.
// A pixel passes pipeline stages A to F on its way to the result port; the
// 32-stage pipelined divider forms x/w, y/w and z/w, one quotient bit per
// stage. One pixel is accepted every cycle while the back end is not stalled.
// A load item is held off (req_full high) until all earlier pixels have left
// the arithmetic pipeline, so each pixel sees the coefficients in force when
// it arrived.
// Reset is synchronous; it clears the coefficients to zero and empties both
// queues and the pipeline. When the receiver stops popping, the result queue
// fills, the pipeline freezes and the pixel queue then raises req_full.
module disparity_to_point_reprojection (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  drp_pkg::req_type  req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output drp_pkg::rsp_type  rsp_data
);

   logic                      pix_valid;
   drp_pkg::pix_type          pix_data;
   drp_pkg::back_status_type  status;
   drp_pkg::coef_array_type   coefs;

   drp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .pix_valid (pix_valid),
      .pix_data  (pix_data),
      .status    (status),
      .coefs     (coefs)
   );

   drp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pix_valid (pix_valid),
      .pix_data  (pix_data),
      .status    (status),
      .coefs     (coefs),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

[design/drp_checker.sv]
// Port-level checker for the reprojection block and its bind statement.
module drp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_push,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input drp_pkg::rsp_type  rsp_data
);

   // After reset nothing is waiting and the input side is open.
   a_reset_clear: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not clear after reset");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty)
      else $error("waiting result vanished without a transfer");

   // A degenerate point carries only saturated or zero coordinates.
   a_degen_sat: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.degenerate |->
         (rsp_data.point_x == drp_pkg::WORD_MAX || rsp_data.point_x == drp_pkg::WORD_MIN ||
          rsp_data.point_x == 32'sd0) &&
         (rsp_data.point_y == drp_pkg::WORD_MAX || rsp_data.point_y == drp_pkg::WORD_MIN ||
          rsp_data.point_y == 32'sd0) &&
         (rsp_data.point_z == drp_pkg::WORD_MAX || rsp_data.point_z == drp_pkg::WORD_MIN ||
          rsp_data.point_z == 32'sd0))
      else $error("degenerate point with unsaturated coordinate");

endmodule

bind disparity_to_point_reprojection drp_checker u_drp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
